// ===== src/trd_pkg.sv =====
// Package with the item types, queue entry type and constants of the TLS record deframer.
`timescale 1ns / 1ps

package trd_pkg;

    localparam int NUM_DIRECTIONS = 2;
    localparam int RANDOM_BYTES   = 28;
    localparam int HDR_BYTES      = 5;
    localparam int IN_PAYLOAD     = 5;
    localparam int RANDOM_START   = 10;
    localparam int SID_POS        = RANDOM_START + RANDOM_BYTES;
    localparam int QUEUE_DEPTH    = 4;
    localparam int Q_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CT_HANDSHAKE    = 8'd22;
    localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
    localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
    localparam logic [7:0] NO_HS           = 8'd255;

    typedef enum logic [1:0] {
        KIND_RECORD        = 2'd0,
        KIND_CLIENT_RANDOM = 2'd1,
        KIND_SERVER_RANDOM = 2'd2
    } kind_t;

    typedef struct packed {
        logic       direction;
        logic [7:0] data_byte;
    } trd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        out_direction;
        logic [7:0]  record_type;
        logic [15:0] record_version;
        logic [15:0] record_length;
        logic [7:0]  handshake_type;
        logic [15:0] cipher_id;
        logic        cipher_valid;
        logic [4:0]  random_index;
        logic [7:0]  random_byte;
        logic        last;
    } trd_out_t;

    // One entry per input byte that causes results: a random byte, a record end, or both.
    typedef struct packed {
        logic        direction;
        logic [7:0]  record_type;
        logic [15:0] record_version;
        logic [15:0] record_length;
        logic [7:0]  handshake_type;
        logic [15:0] cipher_id;
        logic        cipher_valid;
        logic        has_random;
        logic [4:0]  random_index;
        logic [7:0]  random_byte;
        logic        has_complete;
    } trd_event_t;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } trd_q_status_t;

endpackage

// ===== src/tls_record_deframer.sv =====
// Top level of the TLS record deframer: parser, event queue and result stage.
// The input side is a queue write port: an item (direction, data_byte) is taken
// at a rising edge where push is high and full is low. One TCP payload byte of
// either direction may be pushed every cycle; each direction keeps its own parser
// for the 5-byte record header and the record payload.
// The result side is a queue read port: while empty is low the oldest result is
// on result, and it is taken at a rising edge where pop is high.
// A byte causes zero, one or two results: a hello random byte, a record-complete
// report, or both (random first). The last flag marks the final result of a byte.
// A result passes through the event queue and the output register before it shows on
// the result port; the second result of a byte is loaded when the first is taken.
// The parser handles one byte per cycle while full is low, and the result stage sends
// one result per cycle while the receiver pops. The four-entry event queue absorbs the
// second result of a two-result byte, so with the receiver always ready full stays low.
// When the receiver stalls, the held result stays put, the queue fills, and full
// rises; no item is dropped.
// Reset clears all parser state (handshake type reads as 255) and empties the queue.
`timescale 1ns / 1ps

module tls_record_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  trd_pkg::trd_in_t  request,
    output logic              empty,
    input  logic              pop,
    output trd_pkg::trd_out_t result
);
    import trd_pkg::*;

    logic          accept;
    logic          ev_push;
    trd_event_t    ev;
    trd_event_t    head;
    trd_q_status_t q_status;
    logic          q_pop;

    assign full   = !q_status.not_full;
    assign accept = push && !full;

    trd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .ev_push (ev_push),
        .ev      (ev)
    );

    trd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_push),
        .wr_data (ev),
        .rd_en   (q_pop),
        .rd_data (head),
        .status  (q_status)
    );

    trd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

// ===== src/trd_front.sv =====
// Per-direction record parser that classifies each byte and emits events.
`timescale 1ns / 1ps

module trd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  trd_pkg::trd_in_t   request,
    output logic               ev_push,
    output trd_pkg::trd_event_t ev
);
    import trd_pkg::*;

    logic [2:0]  header_count_reg [NUM_DIRECTIONS];
    logic [7:0]  record_type_reg  [NUM_DIRECTIONS];
    logic [15:0] version_reg      [NUM_DIRECTIONS];
    logic [15:0] length_reg       [NUM_DIRECTIONS];
    logic [15:0] position_reg     [NUM_DIRECTIONS];
    logic [7:0]  hs_type_reg      [NUM_DIRECTIONS];
    logic [7:0]  sid_length_reg   [NUM_DIRECTIONS];
    logic [16:0] cipher_reg       [NUM_DIRECTIONS];

    logic [2:0]  header_count_next;
    logic [7:0]  record_type_next;
    logic [15:0] version_next;
    logic [15:0] length_next;
    logic [15:0] position_next;
    logic [7:0]  hs_type_next;
    logic [7:0]  sid_length_next;
    logic [16:0] cipher_next;

    logic        d;
    logic [7:0]  b;
    logic        dir_ok;
    logic        update;
    logic        has_random;
    logic        has_complete;
    logic [4:0]  random_index;
    logic [16:0] cs_pos;
    logic [15:0] p;

    assign d      = request.direction;
    assign b      = request.data_byte;
    assign dir_ok = (32'(d) < NUM_DIRECTIONS);
    assign update = accept && dir_ok;
    assign p      = position_reg[d];
    assign cs_pos = 17'(SID_POS) + 17'd1 + {9'd0, sid_length_reg[d]};

    always_comb
    begin
        header_count_next = header_count_reg[d];
        record_type_next  = record_type_reg[d];
        version_next      = version_reg[d];
        length_next       = length_reg[d];
        position_next     = p;
        hs_type_next      = hs_type_reg[d];
        sid_length_next   = sid_length_reg[d];
        cipher_next       = cipher_reg[d];
        has_random        = 1'b0;
        has_complete      = 1'b0;
        random_index      = '0;
        if (header_count_reg[d] < 3'(IN_PAYLOAD))
        begin
            unique case (header_count_reg[d])
                3'd0:    record_type_next = b;
                3'd1:    version_next = {b, 8'h00};
                3'd2:    version_next = {version_reg[d][15:8], b};
                3'd3:    length_next = {b, 8'h00};
                default: length_next = {length_reg[d][15:8], b};
            endcase
            if (header_count_reg[d] < 3'(HDR_BYTES - 1))
            begin
                header_count_next = header_count_reg[d] + 3'd1;
            end
            else
            begin
                position_next   = '0;
                hs_type_next    = NO_HS;
                sid_length_next = '0;
                cipher_next     = '0;
                if (length_next == 16'd0)
                begin
                    header_count_next = '0;
                    has_complete      = 1'b1;
                end
                else
                begin
                    header_count_next = 3'(IN_PAYLOAD);
                end
            end
        end
        else
        begin
            if (record_type_reg[d] == CT_HANDSHAKE)
            begin
                if (p == 16'd0)
                begin
                    hs_type_next = b;
                end
                else if (hs_type_reg[d] == HS_CLIENT_HELLO || hs_type_reg[d] == HS_SERVER_HELLO)
                begin
                    if (p >= 16'(RANDOM_START) && p < 16'(SID_POS))
                    begin
                        has_random   = 1'b1;
                        random_index = 5'(p - 16'(RANDOM_START));
                    end
                    else if (hs_type_reg[d] == HS_SERVER_HELLO)
                    begin
                        if (p == 16'(SID_POS))
                        begin
                            sid_length_next = b;
                        end
                        else if ({1'b0, p} == cs_pos)
                        begin
                            cipher_next = {1'b0, b, 8'h00};
                        end
                        else if ({1'b0, p} == cs_pos + 17'd1)
                        begin
                            cipher_next = {1'b1, cipher_reg[d][15:8], b};
                        end
                    end
                end
            end
            position_next = p + 16'd1;
            if ({1'b0, p} + 17'd1 >= {1'b0, length_reg[d]})
            begin
                has_complete      = 1'b1;
                header_count_next = '0;
            end
        end
    end

    always_comb
    begin
        ev.direction      = d;
        ev.record_type    = record_type_next;
        ev.record_version = version_next;
        ev.record_length  = length_next;
        ev.handshake_type = hs_type_next;
        ev.cipher_id      = cipher_next[16] ? cipher_next[15:0] : 16'd0;
        ev.cipher_valid   = cipher_next[16];
        ev.has_random     = has_random;
        ev.random_index   = random_index;
        ev.random_byte    = b;
        ev.has_complete   = has_complete;
    end

    assign ev_push = update && (has_random || has_complete);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIRECTIONS; i++)
            begin
                header_count_reg[i] <= '0;
                record_type_reg[i]  <= '0;
                version_reg[i]      <= '0;
                length_reg[i]       <= '0;
                position_reg[i]     <= '0;
                hs_type_reg[i]      <= NO_HS;
                sid_length_reg[i]   <= '0;
                cipher_reg[i]       <= '0;
            end
        end
        else if (update)
        begin
            header_count_reg[d] <= header_count_next;
            record_type_reg[d]  <= record_type_next;
            version_reg[d]      <= version_next;
            length_reg[d]       <= length_next;
            position_reg[d]     <= position_next;
            hs_type_reg[d]      <= hs_type_next;
            sid_length_reg[d]   <= sid_length_next;
            cipher_reg[d]       <= cipher_next;
        end
    end

endmodule

// ===== src/trd_queue.sv =====
// Short event queue between the parser and the result stage.
`timescale 1ns / 1ps

module trd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  trd_pkg::trd_event_t     wr_data,
    input  logic                    rd_en,
    output trd_pkg::trd_event_t     rd_data,
    output trd_pkg::trd_q_status_t  status
);
    import trd_pkg::*;

    trd_event_t         entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign status.not_empty = (count_reg != '0);
    assign status.not_full  = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign do_wr   = wr_en && status.not_full;
    assign do_rd   = rd_en && status.not_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/trd_back.sv =====
// Result stage that expands queued events into items and holds them in an output register.
`timescale 1ns / 1ps

module trd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  trd_pkg::trd_event_t     head,
    input  trd_pkg::trd_q_status_t  q_status,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output trd_pkg::trd_out_t       result
);
    import trd_pkg::*;

    logic     out_valid_reg;
    logic     out_valid_next;
    trd_out_t out_item_reg;
    trd_out_t out_item_next;
    logic     phase_reg;
    logic     phase_next;
    logic     load;
    logic     send_random;

    assign load        = !out_valid_reg || pop;
    assign send_random = head.has_random && !phase_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        q_pop          = 1'b0;
        out_item_next  = out_item_reg;
        if (load)
        begin
            out_valid_next = q_status.not_empty;
            out_item_next.out_direction  = head.direction;
            out_item_next.record_type    = head.record_type;
            out_item_next.record_version = head.record_version;
            out_item_next.record_length  = head.record_length;
            out_item_next.handshake_type = head.handshake_type;
            if (send_random)
            begin
                out_item_next.kind = (head.handshake_type == HS_CLIENT_HELLO) ?
                                     KIND_CLIENT_RANDOM : KIND_SERVER_RANDOM;
                out_item_next.cipher_id    = '0;
                out_item_next.cipher_valid = 1'b0;
                out_item_next.random_index = head.random_index;
                out_item_next.random_byte  = head.random_byte;
                out_item_next.last         = !head.has_complete;
            end
            else
            begin
                out_item_next.kind         = KIND_RECORD;
                out_item_next.cipher_id    = head.cipher_id;
                out_item_next.cipher_valid = head.cipher_valid;
                out_item_next.random_index = '0;
                out_item_next.random_byte  = '0;
                out_item_next.last         = 1'b1;
            end
            if (q_status.not_empty)
            begin
                if (send_random && head.has_complete)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next = 1'b0;
                    q_pop      = 1'b1;
                end
            end
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_item_reg;

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

endmodule
